[hw/rtl/ncst_pkg.sv]
// ============================================================================
// ncst_pkg
// Shared types and codes for the named counting semaphore table.
// ============================================================================
package ncst_pkg;

	localparam int KEY_W   = 64;
	localparam int INIT_W  = 15;
	localparam int IDX_W   = 5;
	localparam int TASK_W  = 6;

	typedef enum logic [1:0] {
		OP_OPEN   = 2'd0,
		OP_WAIT   = 2'd1,
		OP_POST   = 2'd2,
		OP_UNLINK = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_MISS   = 3'd1,
		ST_UNUSED = 3'd2,
		ST_FULL   = 3'd3,
		ST_LIMIT  = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [IDX_W-1:0]  sem_index;
		logic [TASK_W-1:0] caller_task;
		logic [KEY_W-1:0]  name_key;
		logic [INIT_W-1:0] initial_count;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [IDX_W-1:0]  slot_out;
		logic              caller_blocked;
		logic              wake_valid;
		logic [TASK_W-1:0] wake_task;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_EXEC,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item, restart scan
		logic scan_step; // compare one slot, advance
		logic rd;        // read queue head entry
		logic exec;      // perform update, form result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
		logic need_scan;
	} stat_t;

endpackage

[hw/rtl/named_counting_semaphore_table_top.sv]
// ============================================================================
// named_counting_semaphore_table_top
// Table of named counting semaphores with per-slot FIFO wait queues.
// ============================================================================
// Flow: each accepted item passes the scan, read, execute and output states;
// open and unlink search the slot keys in the scan state, which reads one slot
// key per cycle from the key memory; wait and post pass straight through it.
// No new item is taken while one is in flight; a new item is taken in the
// cycle the result leaves.
// Reset: arst_n clears slot used bits, counts and queue pointers at once.
module named_counting_semaphore_table_top import ncst_pkg::*; #(
	parameter int NUM_SEMS    = 32,
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_TASKS   = 64,
	parameter int COUNT_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	cmd_t  cmd;
	stat_t stat;

	// sequence each item through its phases
	ncst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// hold the table, scan keys, update counts and queues
	ncst_datapath #(
		.NUM_SEMS    (NUM_SEMS),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_TASKS   (MAX_TASKS),
		.COUNT_BITS  (COUNT_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.in_item (in_data),
		.stat    (stat),
		.result  (out_data)
	);

endmodule

[hw/rtl/ncst_datapath.sv]
// ============================================================================
// ncst_datapath
// Slot table, key scan, wait queue memory and result formation.
// ============================================================================
module ncst_datapath import ncst_pkg::*; #(
	parameter int NUM_SEMS    = 32,
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_TASKS   = 64,
	parameter int COUNT_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	input  in_item_t  in_item,
	output stat_t     stat,
	output out_item_t result
);
	localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int TW = $clog2(MAX_TASKS);
	localparam int CW = COUNT_BITS;
	localparam int TASK_N = 2 ** TASK_W;
	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

	logic [NUM_SEMS-1:0]  used_q;
	logic [KEY_W-1:0]     key_mem [NUM_SEMS];
	logic signed [CW-1:0] count_q [NUM_SEMS];
	logic [QW-1:0]        head_q  [NUM_SEMS];
	logic [QW-1:0]        tail_q  [NUM_SEMS];
	logic [TW-1:0]        qmem    [NUM_SEMS][QUEUE_DEPTH];

	in_item_t item_q;
	logic [SW:0]   scan_q;
	logic          hit_q, free_q;
	logic [SW-1:0] hit_slot_q, free_slot_q;
	logic [KEY_W-1:0] key_rd_q;
	logic [TW-1:0]    task_rd_q;
	logic [SW-1:0]    tgt;
	logic             idx_ok;
	logic signed [CW-1:0] cnt;
	logic [QW-1:0]    hd, tl, ntl, nhd;
	logic [SW-1:0]    sidx;
	logic [TW-1:0]    task_mod [TASK_N];

	// task id reduced modulo MAX_TASKS, as a constant table
	for (genvar g = 0; g < TASK_N; g++) begin : g_task_mod
		assign task_mod[g] = TW'(g % MAX_TASKS);
	end

	assign sidx = scan_q[SW-1:0];
	assign idx_ok = (32'(item_q.sem_index) < NUM_SEMS);
	assign tgt = idx_ok ? SW'(item_q.sem_index) : '0;
	assign cnt = count_q[tgt];
	assign hd  = head_q[tgt];
	assign tl  = tail_q[tgt];
	assign ntl = (tl == QW'(QUEUE_DEPTH - 1)) ? '0 : tl + 1'b1;
	assign nhd = (hd == QW'(QUEUE_DEPTH - 1)) ? '0 : hd + 1'b1;

	assign stat.scan_done = (32'(scan_q) >= NUM_SEMS);
	assign stat.need_scan = (item_q.opcode == OP_OPEN) || (item_q.opcode == OP_UNLINK);

	// key read for the scan: registered memory read
	always_ff @(posedge clk) begin
		if (cmd.scan_step || cmd.load) begin
			key_rd_q <= key_mem[cmd.load ? SW'(0) : sidx];
		end
		if (cmd.rd) begin
			task_rd_q <= qmem[tgt][hd];
		end
	end

	// scan: compare slot scan_q-1 whose key was read last cycle
	logic [SW:0]   prev;
	logic [SW-1:0] prev_s;
	assign prev   = scan_q - 1'b1;
	assign prev_s = prev[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.load) begin
			scan_q <= (SW+1)'(1);
			hit_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (!stat.scan_done) begin
				scan_q <= scan_q + 1'b1;
			end
			if (32'(prev) < NUM_SEMS) begin
				if (used_q[prev_s] && key_rd_q == item_q.name_key && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!used_q[prev_s] && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (32'(prev) >= NUM_SEMS) begin
				scan_q <= (SW+1)'(NUM_SEMS + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
		end
		if (cmd.scan_step && 32'(prev) < NUM_SEMS) begin
			if (used_q[prev_s] && key_rd_q == item_q.name_key && !hit_q) begin
				hit_slot_q <= prev_s;
			end
			if (!used_q[prev_s] && !free_q) begin
				free_slot_q <= prev_s;
			end
		end
	end

	// execute: update state and register result
	logic signed [CW-1:0] init_c;
	logic                 init_big;
	assign init_big = (INIT_W >= CW) && ((32'(item_q.initial_count)) > 32'(CMAX));
	assign init_c   = CW'($signed({1'b0, item_q.initial_count}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < NUM_SEMS; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
			end
			result <= '0;
		end else if (cmd.exec) begin
			result <= '0;
			unique case (op_t'(item_q.opcode))
				OP_OPEN: begin
					if (hit_q) begin
						result.slot_out <= IDX_W'(hit_slot_q);
					end else if (!free_q) begin
						result.status <= ST_MISS;
					end else if (init_big) begin
						result.status <= ST_LIMIT;
					end else begin
						used_q[free_slot_q]  <= 1'b1;
						count_q[free_slot_q] <= init_c;
						head_q[free_slot_q]  <= '0;
						tail_q[free_slot_q]  <= '0;
						result.slot_out      <= IDX_W'(free_slot_q);
					end
				end
				OP_UNLINK: begin
					if (!hit_q) begin
						result.status <= ST_MISS;
					end else begin
						used_q[hit_slot_q]  <= 1'b0;
						count_q[hit_slot_q] <= '0;
					end
				end
				OP_WAIT: begin
					if (!idx_ok || !used_q[tgt]) begin
						result.status <= ST_UNUSED;
					end else if (cnt == CMIN) begin
						result.status <= ST_LIMIT;
					end else if (cnt <= 0) begin
						if (ntl == hd) begin
							result.status <= ST_FULL;
						end else begin
							tail_q[tgt]  <= ntl;
							count_q[tgt] <= cnt - 1'b1;
							result.caller_blocked <= 1'b1;
						end
					end else begin
						count_q[tgt] <= cnt - 1'b1;
					end
				end
				OP_POST: begin
					if (!idx_ok || !used_q[tgt]) begin
						result.status <= ST_UNUSED;
					end else if (cnt == CMAX) begin
						result.status <= ST_LIMIT;
					end else begin
						count_q[tgt] <= cnt + 1'b1;
						if (cnt < 0 && hd != tl) begin
							result.wake_valid <= 1'b1;
							result.wake_task  <= TASK_W'(task_rd_q);
							head_q[tgt] <= nhd;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload stores: keys and queued task ids
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (item_q.opcode == OP_OPEN && !hit_q && free_q && !init_big) begin
				key_mem[free_slot_q] <= item_q.name_key;
			end
			if (item_q.opcode == OP_WAIT && idx_ok && used_q[tgt] && cnt != CMIN
			    && cnt <= 0 && ntl != hd) begin
				qmem[tgt][tl] <= task_mod[item_q.caller_task];
			end
		end
	end

endmodule

[hw/rtl/ncst_ctrl.sv]
// ============================================================================
// ncst_ctrl
// Sequencer for one item: load, optional key scan, read, execute, deliver.
// ============================================================================
module ncst_ctrl import ncst_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.need_scan) begin
					state_d = S_READ;
				end else begin
					cmd.scan_step = 1'b1;
					if (stat.scan_done) begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				if (out_ready) begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = S_SCAN;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[hw/rtl/ncst_checker.sv]
// ============================================================================
// ncst_sva
// Port-level checks on the semaphore table.
// ============================================================================
module ncst_sva import ncst_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.caller_blocked && out_data.wake_valid))
		else $error("blocked and wake together");
	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.wake_valid |-> out_data.status == ST_OK)
		else $error("wake with error status");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while busy");
endmodule

bind named_counting_semaphore_table_top ncst_sva u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

[bench/ncst_checker.sv]
// ----------------------------------------------------------------------------
// ncst_checker
// Watches both channels of the semaphore table, predicts every result from
// its own copy of the slot table and wait rings, and compares in order.
// ----------------------------------------------------------------------------
module ncst_checker import ncst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending,
	output int        seen_blocked,
	output int        seen_wakes
);

	localparam int SEMS  = 32;
	localparam int DEPTH = 16;
	localparam int CMAX  = 32767;
	localparam int CMIN  = -32768;

	logic        used_q [SEMS];
	logic [63:0] key_q [SEMS];
	int          count_q [SEMS];
	int          head_q [SEMS];
	int          tail_q [SEMS];
	logic [5:0]  ring_q [SEMS][DEPTH];
	out_item_t   expected_q [$];

	initial begin
		fail_count   = 0;
		seen_blocked = 0;
		seen_wakes   = 0;
		for (int i = 0; i < SEMS; i++) begin
			used_q[i]  = 1'b0;
			count_q[i] = 0;
			head_q[i]  = 0;
			tail_q[i]  = 0;
		end
	end

	assign pending = expected_q.size();

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic out_item_t semaphore_step(input in_item_t it);
		out_item_t r;
		int s;
		int c;
		int nt;
		int idx;
		r = '0;
		r.status = ST_OK;
		idx = int'(it.sem_index);
		s = -1;
		if (it.opcode == OP_OPEN || it.opcode == OP_UNLINK)
			for (int i = SEMS - 1; i >= 0; i--)
				if (used_q[i] && key_q[i] == it.name_key)
					s = i;
		if (it.opcode == OP_OPEN) begin
			if (s >= 0) begin
				r.slot_out = 5'(s);
			end else begin
				for (int i = SEMS - 1; i >= 0; i--)
					if (!used_q[i])
						s = i;
				if (s < 0) begin
					r.status = ST_MISS;
				end else begin
					used_q[s]  = 1'b1;
					key_q[s]   = it.name_key;
					count_q[s] = int'(it.initial_count);
					head_q[s]  = 0;
					tail_q[s]  = 0;
					r.slot_out = 5'(s);
				end
			end
		end else if (it.opcode == OP_UNLINK) begin
			if (s < 0) begin
				r.status = ST_MISS;
			end else begin
				used_q[s]  = 1'b0;
				count_q[s] = 0;
			end
		end else if (!used_q[idx]) begin
			r.status = ST_UNUSED;
		end else if (it.opcode == OP_WAIT) begin
			c = count_q[idx];
			if (c <= CMIN) begin
				r.status = ST_LIMIT;
			end else if (c - 1 < 0) begin
				nt = (tail_q[idx] + 1) % DEPTH;
				if (nt == head_q[idx]) begin
					r.status = ST_FULL;
				end else begin
					ring_q[idx][tail_q[idx]] = it.caller_task;
					tail_q[idx]  = nt;
					count_q[idx] = c - 1;
					r.caller_blocked = 1'b1;
				end
			end else begin
				count_q[idx] = c - 1;
			end
		end else begin
			c = count_q[idx];
			if (c >= CMAX) begin
				r.status = ST_LIMIT;
			end else begin
				count_q[idx] = c + 1;
				if (c + 1 <= 0 && head_q[idx] != tail_q[idx]) begin
					r.wake_valid = 1'b1;
					r.wake_task  = ring_q[idx][head_q[idx]];
					head_q[idx]  = (head_q[idx] + 1) % DEPTH;
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		out_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report("result with nothing expected");
			end else begin
				e = expected_q.pop_front();
				if (out_data.status !== e.status)
					report($sformatf("status %0d, want %0d", out_data.status, e.status));
				if (out_data.slot_out !== e.slot_out)
					report($sformatf("slot %0d, want %0d", out_data.slot_out, e.slot_out));
				if (out_data.caller_blocked !== e.caller_blocked)
					report("caller_blocked differs");
				if (out_data.wake_valid !== e.wake_valid)
					report("wake_valid differs");
				if (out_data.wake_task !== e.wake_task)
					report($sformatf("wake task %0d, want %0d", out_data.wake_task,
						e.wake_task));
				if (e.caller_blocked)
					seen_blocked++;
				if (e.wake_valid)
					seen_wakes++;
			end
		end
		// predict after the compare so a same-edge accept cannot be consumed early
		if (arst_n && in_valid && in_ready)
			expected_q.push_back(semaphore_step(in_data));
	end

endmodule

[bench/named_counting_semaphore_table_top_tb.sv]
// ----------------------------------------------------------------------------
// named_counting_semaphore_table_top_tb
// Drives open, wait, post and unlink items into the semaphore table under
// several idling phases and a long output stall; a checker scores results.
// ----------------------------------------------------------------------------
module named_counting_semaphore_table_top_tb;
	import ncst_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	int fail_count;
	int pending;
	int seen_blocked;
	int seen_wakes;
	int sender_idle_pct;
	int receiver_stall_pct;
	int hold_off_cycles;
	int items_sent;

	// small key pool so opens hit and miss, and unlinks find keys
	logic [63:0] key_pool [8];

	named_counting_semaphore_table_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	ncst_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.seen_blocked(seen_blocked),
		.seen_wakes  (seen_wakes)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: a hold-off wins over random stalls; count it down here.
	initial begin
		out_ready = 1'b0;
		hold_off_cycles = 0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= receiver_stall_pct);
			end
		end
	end

	// Offer one item and hold it until accepted, with a random gap first.
	// Valid stays high after the accept so the next item can follow at once.
	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_op(input op_t op, input int idx, input int tsk,
			input logic [63:0] key, input int init);
		in_item_t it;
		it.opcode        = op;
		it.sem_index     = 5'(idx);
		it.caller_task   = 6'(tsk);
		it.name_key      = key;
		it.initial_count = 15'(init);
		send_item(it);
	endtask

	// Pause the sender until every expected result is back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mostly well-formed traffic over a few live slots with random content.
	task automatic random_items(input int n);
		in_item_t it;
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			it.sem_index     = 5'(($urandom_range(9) == 0) ? $urandom_range(31) :
				$urandom_range(5));
			it.caller_task   = 6'($urandom_range(63));
			it.name_key      = ($urandom_range(7) == 0) ? {$urandom, $urandom} :
				key_pool[$urandom_range(7)];
			it.initial_count = 15'(($urandom_range(15) == 0) ? $urandom_range(32767) :
				$urandom_range(3));
			if (r < 12)
				it.opcode = OP_OPEN;
			else if (r < 55)
				it.opcode = OP_WAIT;
			else if (r < 95)
				it.opcode = OP_POST;
			else
				it.opcode = OP_UNLINK;
			send_item(it);
		end
	endtask

	initial begin
		in_valid = 1'b0;
		in_data  = '0;
		arst_n   = 1'b0;
		items_sent = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		for (int i = 0; i < 8; i++)
			key_pool[i] = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unused slot, out-of-use index, extremes of count and key.
		send_op(OP_WAIT, 31, 0, '0, 0);
		send_op(OP_POST, 0, 0, '0, 0);
		send_op(OP_UNLINK, 0, 0, '1, 0);
		send_op(OP_OPEN, 0, 0, key_pool[0], 0);
		send_op(OP_OPEN, 0, 0, key_pool[1], 32767);
		send_op(OP_OPEN, 0, 0, key_pool[0], 5);          // existing key: count ignored
		send_op(OP_POST, 1, 0, '0, 0);                   // count ceiling
		// fill the ring of slot 0: 15 blocked, the sixteenth reports queue full
		for (int i = 0; i < 16; i++)
			send_op(OP_WAIT, 0, 63 - i * 4, '0, 0);
		send_op(OP_POST, 0, 0, '0, 0);                   // wake oldest
		send_op(OP_UNLINK, 0, 0, key_pool[0], 0);        // unlink with waiters
		send_op(OP_OPEN, 0, 42, key_pool[2], 0);         // reopen empties queue
		send_op(OP_POST, 0, 0, '0, 0);                   // count above zero, no wake
		drain_results();

		// Fill the table so an open finds no free slot.
		for (int i = 0; i < 31; i++)
			send_op(OP_OPEN, 0, 0, {32'hA5A5_0000, i}, 1);
		send_op(OP_OPEN, 0, 0, 64'hDEAD_BEEF, 1);
		for (int i = 0; i < 31; i++)
			send_op(OP_UNLINK, 0, 0, {32'hA5A5_0000, i}, 0);
		drain_results();

		// Reopen slot 1 from a zero count for the random traffic.
		send_op(OP_UNLINK, 0, 0, key_pool[1], 0);
		send_op(OP_OPEN, 0, 0, key_pool[1], 0);
		drain_results();

		// Random phases with different idling.
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct    = (phase == 1 || phase == 3) ? ((phase == 3) ? 26 : 48) : 0;
			receiver_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 26 : 48) : 0;
			random_items(170);
			if (phase == 1) begin
				// long output stall while items keep coming: the block backs up
				hold_off_cycles = 300;
				random_items(10);
			end
			drain_results();
		end

		repeat (60) @(posedge clk);
		$display("ran %0d items through open/wait/post/unlink under idle and stall phases",
			items_sent);
		$display("saw %0d blocked waits and %0d wakes", seen_blocked, seen_wakes);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
